// ===== rtl/core/ftpcp_pkg.sv =====
// ftpcp_pkg: sizes, codes and state type of the frame to page column packer
// no dependencies; used by frame_to_page_column_packer, ftpcp_checker and the bench
package ftpcp_pkg;

    localparam int MAX_COLUMNS   = 128;
    localparam int MAX_ROWS      = 64;
    localparam int ROWS_PER_PAGE = 8;
    localparam int MAX_PAGES     = MAX_ROWS / ROWS_PER_PAGE;
    localparam int STORE_DEPTH   = MAX_COLUMNS * MAX_PAGES;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int PAGE_W        = $clog2(MAX_PAGES + 1);
    localparam int WIDTH_W       = $clog2(MAX_COLUMNS + 1) + 1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [1:0] REG_PANEL_WIDTH  = 2'd0;
    localparam logic [1:0] REG_PANEL_HEIGHT = 2'd1;

    localparam logic [7:0] PANEL_WIDTH_RESET  = 8'd128;
    localparam logic [6:0] PANEL_HEIGHT_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_MOD,
        ST_RD_ISSUE
    } t_fsm_state;

endpackage

// ===== rtl/core/frame_to_page_column_packer.sv =====
// frame_to_page_column_packer: one-bit frame store read back as page bytes
// depends on ftpcp_pkg
//
// After reset a clearing pass writes zero to every store byte, one per cycle
// (STORE_DEPTH bytes, 1024 as built), while no item is taken. A pixel write
// is a read and a write back of one byte of the store. A column read issues
// one store read per page, one byte result per cycle while the output side
// keeps up; a two-entry output stage lets the next item in while results
// still wait. Configuration writes are taken at any time and should only be
// made while idle.
module frame_to_page_column_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [6:0]  i_column,
    input  logic [5:0]  i_row,
    input  logic [15:0] i_pixel,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_page_byte,
    output logic [2:0]  o_page_index,
    output logic        o_last_byte
);

    localparam int AW = ftpcp_pkg::ADDR_W;
    localparam int PW = ftpcp_pkg::PAGE_W;
    localparam int WW = ftpcp_pkg::WIDTH_W;

    ftpcp_pkg::t_fsm_state r_state, n_state;

    logic [7:0] r_panel_width;
    logic [6:0] r_panel_height;

    logic [7:0] r_mem [ftpcp_pkg::STORE_DEPTH];
    logic [7:0] r_mem_rdata;
    logic       mem_we;
    logic       mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_wdata;

    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] r_wr_addr;
    logic [2:0]    r_wr_bit;
    logic          r_wr_set;
    logic [6:0]    r_column;
    logic [PW-1:0] r_pages;
    logic [PW-1:0] r_page;

    logic       r_inflight;
    logic [2:0] r_rd_page;
    logic       r_rd_last;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic [2:0] r_out_page;
    logic       r_out_last;
    logic       r_skid_valid;
    logic [7:0] r_skid_byte;
    logic [2:0] r_skid_page;
    logic       r_skid_last;

    logic [WW-1:0] width_use;
    logic [6:0]    height_use;
    logic [PW-1:0] pages_use;
    logic          col_ok;
    logic          row_ok;
    logic          in_acc;
    logic          out_acc;
    logic          wr_go;
    logic          rd_go;
    logic          issue_ok;
    logic          issue;
    logic          clr_done;
    logic          page_last;
    logic [1:0]    occupancy;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    wr_mask;

    // limits in use
    always_comb begin
        if (WW'(r_panel_width) > WW'(ftpcp_pkg::MAX_COLUMNS)) begin
            width_use = WW'(ftpcp_pkg::MAX_COLUMNS);
        end else begin
            width_use = WW'(r_panel_width);
        end
        if (r_panel_height > 7'(ftpcp_pkg::MAX_ROWS)) begin
            height_use = 7'(ftpcp_pkg::MAX_ROWS);
        end else begin
            height_use = r_panel_height;
        end
        pages_use = PW'(height_use / ftpcp_pkg::ROWS_PER_PAGE);
    end

    assign col_ok  = WW'(i_column) < width_use;
    assign row_ok  = 7'(i_row) < height_use;
    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = r_out_valid && i_out_ready;
    assign wr_go   = in_acc && (i_command == ftpcp_pkg::CMD_WRITE) && col_ok && row_ok;
    assign rd_go   = in_acc && (i_command == ftpcp_pkg::CMD_READ) && col_ok
                     && (pages_use != '0);

    assign in_addr = AW'(int'(i_column) * ftpcp_pkg::MAX_PAGES
                     + int'(i_row) / ftpcp_pkg::ROWS_PER_PAGE);
    assign rd_addr = AW'(int'(r_column) * ftpcp_pkg::MAX_PAGES + int'(r_page));
    assign wr_mask = 8'(1) << r_wr_bit;

    assign clr_done  = r_clr_addr == AW'(ftpcp_pkg::STORE_DEPTH - 1);
    assign page_last = PW'(r_page + PW'(1)) == r_pages;

    // results held in the read stage, output and skid, less one leaving now
    assign occupancy = 2'(r_inflight) + 2'(r_out_valid) + 2'(r_skid_valid)
                       - 2'(out_acc);
    assign issue_ok  = occupancy < 2'd2;
    assign issue     = (r_state == ftpcp_pkg::ST_RD_ISSUE) && issue_ok;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ftpcp_pkg::ST_CLEAR: begin
                if (clr_done) begin
                    n_state = ftpcp_pkg::ST_IDLE;
                end
            end
            ftpcp_pkg::ST_IDLE: begin
                if (wr_go) begin
                    n_state = ftpcp_pkg::ST_WR_MOD;
                end else if (rd_go) begin
                    n_state = ftpcp_pkg::ST_RD_ISSUE;
                end
            end
            ftpcp_pkg::ST_WR_MOD: begin
                n_state = ftpcp_pkg::ST_IDLE;
            end
            ftpcp_pkg::ST_RD_ISSUE: begin
                if (issue_ok && page_last) begin
                    n_state = ftpcp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ftpcp_pkg::ST_CLEAR;
            end
        endcase
    end

    // fsm outputs and store control
    always_comb begin
        o_in_ready = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = r_wr_addr;
        mem_raddr  = rd_addr;
        mem_wdata  = '0;
        case (r_state)
            ftpcp_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
            end
            ftpcp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                mem_re     = wr_go;
                mem_raddr  = in_addr;
            end
            ftpcp_pkg::ST_WR_MOD: begin
                mem_we = 1'b1;
                if (r_wr_set) begin
                    mem_wdata = r_mem_rdata | wr_mask;
                end else begin
                    mem_wdata = r_mem_rdata & ~wr_mask;
                end
            end
            ftpcp_pkg::ST_RD_ISSUE: begin
                mem_re = issue_ok;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // frame store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_rdata <= r_mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ftpcp_pkg::ST_CLEAR;
            r_clr_addr     <= '0;
            r_panel_width  <= ftpcp_pkg::PANEL_WIDTH_RESET;
            r_panel_height <= ftpcp_pkg::PANEL_HEIGHT_RESET;
            r_page         <= '0;
            r_inflight     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_skid_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ftpcp_pkg::ST_CLEAR) begin
                r_clr_addr <= AW'(r_clr_addr + AW'(1));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == ftpcp_pkg::REG_PANEL_WIDTH) begin
                    r_panel_width <= i_cfg_data;
                end else if (i_cfg_index == ftpcp_pkg::REG_PANEL_HEIGHT) begin
                    r_panel_height <= i_cfg_data[6:0];
                end
            end
            if (rd_go) begin
                r_page <= '0;
            end else if (issue) begin
                r_page <= PW'(r_page + PW'(1));
            end
            r_inflight <= issue;
            // output stage and skid, order kept
            if (r_skid_valid) begin
                if (out_acc) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= r_inflight;
                end
            end else if (r_inflight) begin
                if (!r_out_valid || out_acc) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_wr_addr <= in_addr;
            r_wr_bit  <= 3'(i_row % ftpcp_pkg::ROWS_PER_PAGE);
            r_wr_set  <= i_pixel != '0;
        end
        if (rd_go) begin
            r_column <= i_column;
            r_pages  <= pages_use;
        end
        if (issue) begin
            r_rd_page <= 3'(r_page);
            r_rd_last <= page_last;
        end
        if (r_skid_valid) begin
            if (out_acc) begin
                r_out_byte <= r_skid_byte;
                r_out_page <= r_skid_page;
                r_out_last <= r_skid_last;
                if (r_inflight) begin
                    r_skid_byte <= r_mem_rdata;
                    r_skid_page <= r_rd_page;
                    r_skid_last <= r_rd_last;
                end
            end
        end else if (r_inflight) begin
            if (!r_out_valid || out_acc) begin
                r_out_byte <= r_mem_rdata;
                r_out_page <= r_rd_page;
                r_out_last <= r_rd_last;
            end else begin
                r_skid_byte <= r_mem_rdata;
                r_skid_page <= r_rd_page;
                r_skid_last <= r_rd_last;
            end
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_page_byte  = r_out_byte;
    assign o_page_index = r_out_page;
    assign o_last_byte  = r_out_last;

endmodule

// ===== rtl/core/ftpcp_checker.sv =====
// ftpcp_checker: port-level assertions for frame_to_page_column_packer
// depends on ftpcp_pkg; bound to the top level below
module ftpcp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_page_byte,
    input logic [2:0] o_page_index,
    input logic       o_last_byte
);

    logic [2:0] r_expect_page;

    // page expected on the next output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_page <= '0;
        end else if (o_out_valid && i_out_ready) begin
            if (o_last_byte) begin
                r_expect_page <= '0;
            end else begin
                r_expect_page <= 3'(o_page_index + 3'd1);
            end
        end
    end

    a_page_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_page_index == r_expect_page)
        else $error("page bytes out of order");

    a_page_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_byte |-> o_page_index != 3'(ftpcp_pkg::MAX_PAGES - 1))
        else $error("column runs past last page");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("item taken during store clear");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_page_byte))
        else $error("stalled result dropped or changed");

endmodule

bind frame_to_page_column_packer ftpcp_checker u_ftpcp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_page_byte  (o_page_byte),
    .o_page_index (o_page_index),
    .o_last_byte  (o_last_byte)
);

// ===== tb/frame_to_page_column_packer_test.sv =====
// frame_to_page_column_packer_test: self-checking bench for the page column packer
// drives pixel writes and column reads through valid/ready, predicts page bytes
// from a local copy of the one-bit frame store; depends on ftpcp_pkg and the rtl
module frame_to_page_column_packer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic        command;
        logic [6:0]  column;
        logic [5:0]  row;
        logic [15:0] pixel;
    } t_pixel_req;

    typedef struct packed {
        logic [7:0] bits;
        logic [2:0] page;
        logic       last;
    } t_page_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_command = 1'b0;
    logic [6:0]  i_column = '0;
    logic [5:0]  i_row = '0;
    logic [15:0] i_pixel = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_page_byte;
    logic [2:0]  o_page_index;
    logic        o_last_byte;

    t_pixel_req pixel_jobs[$];
    t_page_byte column_bytes[$];
    logic [7:0] frame_pages [ftpcp_pkg::STORE_DEPTH];
    logic [7:0] panel_cols = ftpcp_pkg::PANEL_WIDTH_RESET;
    logic [6:0] panel_rows = ftpcp_pkg::PANEL_HEIGHT_RESET;

    t_pixel_req held_req;
    bit         holding = 1'b0;
    int         in_gap = 0;
    int         out_stall = 0;
    bit         in_calm = 1'b0;
    bit         out_calm = 1'b0;
    int         fail_count = 0;
    int         req_count = 0;
    int         byte_count = 0;
    int         setting_count = 0;

    frame_to_page_column_packer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_pixel     (i_pixel),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_page_byte (o_page_byte),
        .o_page_index(o_page_index),
        .o_last_byte (o_last_byte)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int cols_in_use();
        return (panel_cols > ftpcp_pkg::MAX_COLUMNS) ? ftpcp_pkg::MAX_COLUMNS
                                                     : int'(panel_cols);
    endfunction

    function automatic int rows_in_use();
        return (panel_rows > ftpcp_pkg::MAX_ROWS) ? ftpcp_pkg::MAX_ROWS : int'(panel_rows);
    endfunction

    // updates the frame copy on a write, queues the page bytes of a read
    function automatic void apply_pixel_request(t_pixel_req req);
        int w;
        int h;
        int addr;
        int pages;
        t_page_byte pb;
        w = cols_in_use();
        h = rows_in_use();
        if (req.column >= w) return;
        if (req.command == ftpcp_pkg::CMD_WRITE) begin
            if (req.row >= h) return;
            addr = req.column * ftpcp_pkg::MAX_PAGES + req.row / ftpcp_pkg::ROWS_PER_PAGE;
            if (addr >= ftpcp_pkg::STORE_DEPTH) return;
            frame_pages[addr][req.row % ftpcp_pkg::ROWS_PER_PAGE] = (req.pixel != '0);
        end else begin
            pages = h / ftpcp_pkg::ROWS_PER_PAGE;
            if (pages > ftpcp_pkg::MAX_PAGES) pages = ftpcp_pkg::MAX_PAGES;
            for (int p = 0; p < pages; p++) begin
                addr = req.column * ftpcp_pkg::MAX_PAGES + p;
                pb.bits = (addr < ftpcp_pkg::STORE_DEPTH) ? frame_pages[addr] : 8'h00;
                pb.page = 3'(p);
                pb.last = (p + 1 == pages);
                column_bytes.push_back(pb);
            end
        end
    endfunction

    function automatic t_pixel_req random_req();
        t_pixel_req r;
        int w;
        int h;
        w = cols_in_use();
        h = rows_in_use();
        r.command = ($urandom_range(0, 9) < 3) ? ftpcp_pkg::CMD_READ : ftpcp_pkg::CMD_WRITE;
        if (w > 0 && $urandom_range(0, 9) < 8) r.column = 7'($urandom_range(0, w - 1));
        else r.column = 7'($urandom_range(0, 127));
        if (h > 0 && $urandom_range(0, 9) < 8) r.row = 6'($urandom_range(0, h - 1));
        else r.row = 6'($urandom_range(0, 63));
        case ($urandom_range(0, 3))
            0: r.pixel = 16'h0000;
            1: r.pixel = 16'hFFFF;
            2: r.pixel = 16'h0001 << $urandom_range(0, 15);
            default: r.pixel = 16'($urandom);
        endcase
        return r;
    endfunction

    function automatic void add_req(logic cmd, int col, int row, int pix);
        t_pixel_req r;
        r.command = cmd;
        r.column = 7'(col);
        r.row = 6'(row);
        r.pixel = 16'(pix);
        pixel_jobs.push_back(r);
    endfunction

    function automatic void add_random(int count);
        repeat (count) pixel_jobs.push_back(random_req());
    endfunction

    function automatic void report_fail(string what, t_page_byte exp_b, t_page_byte act_b);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s: expected byte %02h page %0d last %0b, got byte %02h page %0d last %0b",
                     what, exp_b.bits, exp_b.page, exp_b.last,
                     act_b.bits, act_b.page, act_b.last);
    endfunction

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == ftpcp_pkg::REG_PANEL_WIDTH) panel_cols = val;
        else if (idx == ftpcp_pkg::REG_PANEL_HEIGHT) panel_rows = val[6:0];
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        while (pixel_jobs.size() != 0 || holding || column_bytes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_panel(input logic [7:0] cols, input logic [7:0] rows,
                             input bit calm_in, input bit calm_out);
        settle();
        cfg_write(ftpcp_pkg::REG_PANEL_WIDTH, cols);
        cfg_write(ftpcp_pkg::REG_PANEL_HEIGHT, rows);
        cfg_write(REG_SPARE_A, 8'($urandom));
        cfg_write(REG_SPARE_B, 8'($urandom));
        setting_count++;
        in_calm = calm_in;
        out_calm = calm_out;
        @(negedge i_clk);
    endtask

    // input side: one request per transfer, random gap after each unless in_calm is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            holding = 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                apply_pixel_request(held_req);
                req_count++;
                holding = 1'b0;
                in_gap = in_calm ? 0 : $urandom_range(0, 12);
            end
            if (!holding) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pixel_jobs.size() != 0) begin
                    held_req = pixel_jobs.pop_front();
                    holding = 1'b1;
                    i_command <= held_req.command;
                    i_column <= held_req.column;
                    i_row <= held_req.row;
                    i_pixel <= held_req.pixel;
                end
            end
            i_in_valid <= holding;
        end
    end

    // output side: compare each page byte transfer, random stall after each unless out_calm is set
    always @(posedge i_clk) begin
        t_page_byte got;
        t_page_byte want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                byte_count++;
                got.bits = o_page_byte;
                got.page = o_page_index;
                got.last = o_last_byte;
                if (column_bytes.size() == 0) begin
                    report_fail("unexpected page byte", '0, got);
                end else begin
                    want = column_bytes.pop_front();
                    if (got !== want) report_fail("page byte mismatch", want, got);
                end
                out_stall = out_calm ? 0 : $urandom_range(0, 12);
            end else if (out_stall > 0) begin
                out_stall--;
            end
            i_out_ready <= (out_stall == 0);
        end
    end

    initial begin
        for (int a = 0; a < ftpcp_pkg::STORE_DEPTH; a++) frame_pages[a] = 8'h00;

        // reset values of the panel registers
        add_req(ftpcp_pkg::CMD_WRITE, 0, 0, 16'h0001);
        add_req(ftpcp_pkg::CMD_WRITE, 0, 7, 16'h8000);
        add_req(ftpcp_pkg::CMD_WRITE, 0, 63, 16'hFFFF);
        add_req(ftpcp_pkg::CMD_WRITE, 127, 56, 16'h0100);
        add_req(ftpcp_pkg::CMD_WRITE, 127, 63, 16'hFFFF);
        add_req(ftpcp_pkg::CMD_READ, 0, 63, 16'hFFFF);
        add_req(ftpcp_pkg::CMD_READ, 127, 0, 16'h0000);
        add_req(ftpcp_pkg::CMD_WRITE, 0, 0, 16'h0000);
        add_req(ftpcp_pkg::CMD_WRITE, 127, 63, 16'h0000);
        add_req(ftpcp_pkg::CMD_READ, 0, 0, 16'h0000);
        add_req(ftpcp_pkg::CMD_READ, 127, 0, 16'h0000);
        add_req(ftpcp_pkg::CMD_READ, 64, 0, 16'h0000);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_panel(8'd40, 8'd24, 1'b1, 1'b0);
        add_req(ftpcp_pkg::CMD_WRITE, 39, 23, 16'h00FF);
        add_req(ftpcp_pkg::CMD_WRITE, 40, 0, 16'h0001);
        add_req(ftpcp_pkg::CMD_WRITE, 3, 24, 16'h0001);
        add_req(ftpcp_pkg::CMD_READ, 40, 0, 16'h0000);
        add_req(ftpcp_pkg::CMD_READ, 39, 0, 16'h0000);
        add_random(40);

        // one column, partial second page
        set_panel(8'd1, 8'd13, 1'b0, 1'b0);
        add_req(ftpcp_pkg::CMD_WRITE, 0, 12, 16'h0001);
        add_req(ftpcp_pkg::CMD_WRITE, 1, 0, 16'h0001);
        add_req(ftpcp_pkg::CMD_READ, 0, 0, 16'h0000);
        add_random(15);

        set_panel(8'd0, 8'd64, 1'b0, 1'b0);
        add_req(ftpcp_pkg::CMD_READ, 0, 0, 16'h0000);
        add_req(ftpcp_pkg::CMD_WRITE, 0, 0, 16'h0001);
        add_random(10);

        // less than one page of rows
        set_panel(8'd128, 8'd7, 1'b0, 1'b1);
        add_req(ftpcp_pkg::CMD_READ, 5, 0, 16'h0000);
        add_req(ftpcp_pkg::CMD_WRITE, 5, 6, 16'h4000);
        add_random(12);

        set_panel(8'd128, 8'd0, 1'b1, 1'b1);
        add_random(5);

        // both registers above the store size
        set_panel(8'd255, 8'd255, 1'b0, 1'b1);
        add_req(ftpcp_pkg::CMD_READ, 0, 0, 16'h0000);
        add_req(ftpcp_pkg::CMD_READ, 5, 0, 16'h0000);
        add_random(45);

        set_panel(8'd8, 8'd8, 1'b0, 1'b0);
        add_random(25);

        set_panel(8'd128, 8'd64, 1'b0, 1'b0);
        add_random(30);

        set_panel(8'd100, 8'd48, 1'b1, 1'b1);
        add_random(25);

        settle();
        if (column_bytes.size() != 0) fail_count++;
        $display("%0d requests over %0d panel settings, %0d page bytes compared",
                 req_count, setting_count + 1, byte_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ftpcp_pkg.sv
rtl/core/frame_to_page_column_packer.sv
rtl/core/ftpcp_checker.sv
tb/frame_to_page_column_packer_test.sv
